@@ hw/rtl/crl_pkg.sv @@
`default_nettype none
// Shared types and codes for the consistent-hash ring lookup block.
// Used by the ring top level; depends on nothing else.
package crl_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 32;
   localparam int NODE_W   = 16;
   localparam int STATUS_W = 3;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

   // Flipping the sign bit turns signed order into unsigned order.
   localparam logic [POS_W-1:0] KEY_FLIP = 32'h8000_0000;

   typedef struct packed {
      logic              valid;
      logic [POS_W-1:0]  position;
      logic [NODE_W-1:0] node;
   } entry_type;

endpackage
`default_nettype wire

@@ hw/rtl/crl_ram.sv @@
`default_nettype none
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instanced by the ring top level.
module crl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/consistent_hash_ring_lookup.sv @@
`default_nettype none
// Top level of the consistent-hash ring lookup block.
// Depends on crl_pkg and crl_ram.
//
// The ring holds up to RING_ENTRIES (position, node) pairs in one RAM, each
// row carrying its own valid bit. Every word, whether insert, remove or
// lookup, scans all RING_ENTRIES rows through the single RAM read port, one
// row per cycle, and then commits its write and result in the finish step,
// which waits while an earlier result is still untaken. After reset the
// block clears the valid bits of every row and accepts no word during that
// pass. A finished result sits in an output register, so the next word is
// taken while it waits.
module consistent_hash_ring_lookup #(
   parameter int RING_ENTRIES = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [crl_pkg::OP_W-1:0]            req_op,
   input  wire logic signed [crl_pkg::POS_W-1:0]    req_position,
   input  wire logic [crl_pkg::NODE_W-1:0]          req_node_id,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [crl_pkg::NODE_W-1:0]          rsp_found_node,
   output logic      [crl_pkg::STATUS_W-1:0]        rsp_status
);

   import crl_pkg::*;

   localparam int AW = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
   localparam int CW = $clog2(RING_ENTRIES + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_ENTRIES - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(RING_ENTRIES);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic              issue_ff, issue_in;
   logic              data_valid_ff, data_valid_in;
   logic              data_last_ff, data_last_in;
   logic [AW-1:0]     data_idx_ff, data_idx_in;
   logic [CW-1:0]     entry_count_ff, entry_count_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [NODE_W-1:0] node_ff, node_in;

   logic              match_found_ff, match_found_in;
   logic [AW-1:0]     match_idx_ff, match_idx_in;
   logic              free_found_ff, free_found_in;
   logic [AW-1:0]     free_idx_ff, free_idx_in;
   logic              min_found_ff, min_found_in;
   logic [POS_W-1:0]  min_key_ff, min_key_in;
   logic [NODE_W-1:0] min_node_ff, min_node_in;
   logic              succ_found_ff, succ_found_in;
   logic [POS_W-1:0]  succ_key_ff, succ_key_in;
   logic [NODE_W-1:0] succ_node_ff, succ_node_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]   rsp_found_node_ff, rsp_found_node_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                     ram_we;
   logic [AW-1:0]            ram_wr_addr;
   entry_type                ram_wr_entry;
   logic [$bits(entry_type)-1:0] ram_rd_data;
   entry_type                rd_entry;
   logic [POS_W-1:0]         rd_key;
   logic [POS_W-1:0]         query_key;
   logic                     req_fire;
   logic                     finish_fire;

   crl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (RING_ENTRIES)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (issue_ff),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry    = entry_type'(ram_rd_data);
   assign rd_key      = rd_entry.position ^ KEY_FLIP;
   assign query_key   = pos_ff ^ KEY_FLIP;
   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign finish_fire = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in          = state_ff;
      addr_in           = addr_ff;
      issue_in          = issue_ff;
      data_valid_in     = issue_ff;
      data_last_in      = issue_ff && (addr_ff == LAST_ADDR);
      data_idx_in       = addr_ff;
      entry_count_in    = entry_count_ff;
      op_in             = op_ff;
      pos_in            = pos_ff;
      node_in           = node_ff;
      match_found_in    = match_found_ff;
      match_idx_in      = match_idx_ff;
      free_found_in     = free_found_ff;
      free_idx_in       = free_idx_ff;
      min_found_in      = min_found_ff;
      min_key_in        = min_key_ff;
      min_node_in       = min_node_ff;
      succ_found_in     = succ_found_ff;
      succ_key_in       = succ_key_ff;
      succ_node_in      = succ_node_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_found_node_in = rsp_found_node_ff;
      rsp_status_in     = rsp_status_ff;
      ram_we            = 1'b0;
      ram_wr_addr       = addr_ff;
      ram_wr_entry      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in          = req_op;
               pos_in         = req_position;
               node_in        = req_node_id;
               addr_in        = '0;
               issue_in       = 1'b1;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               min_found_in   = 1'b0;
               succ_found_in  = 1'b0;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               addr_in = addr_ff + 1'b1;
               if (addr_ff == LAST_ADDR) begin
                  issue_in = 1'b0;
                  addr_in  = '0;
               end
            end
            if (data_valid_ff) begin
               if (rd_entry.valid && rd_entry.position == pos_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = data_idx_ff;
               end
               if (!rd_entry.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = data_idx_ff;
               end
               if (rd_entry.valid && (!min_found_ff || rd_key < min_key_ff)) begin
                  min_found_in = 1'b1;
                  min_key_in   = rd_key;
                  min_node_in  = rd_entry.node;
               end
               if (rd_entry.valid && rd_key >= query_key
                   && (!succ_found_ff || rd_key < succ_key_ff)) begin
                  succ_found_in = 1'b1;
                  succ_key_in   = rd_key;
                  succ_node_in  = rd_entry.node;
               end
               if (data_last_ff) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (finish_fire) begin
               rsp_valid_in      = 1'b1;
               rsp_found_node_in = '0;
               rsp_status_in     = ST_OK;
               state_in          = S_IDLE;
               unique case (op_ff)
                  OP_INSERT: begin
                     if (match_found_ff) begin
                        rsp_status_in = ST_DUP;
                     end else if (entry_count_ff == FULL_COUNT) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ram_we                = 1'b1;
                        ram_wr_addr           = free_idx_ff;
                        ram_wr_entry.valid    = 1'b1;
                        ram_wr_entry.position = pos_ff;
                        ram_wr_entry.node     = node_ff;
                        entry_count_in        = entry_count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (!match_found_ff) begin
                        rsp_status_in = ST_ABSENT;
                     end else begin
                        ram_we         = 1'b1;
                        ram_wr_addr    = match_idx_ff;
                        entry_count_in = entry_count_ff - 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     if (!min_found_ff) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_found_node_in = succ_found_ff ? succ_node_ff : min_node_ff;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         addr_ff        <= '0;
         issue_ff       <= 1'b0;
         data_valid_ff  <= 1'b0;
         data_last_ff   <= 1'b0;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         addr_ff        <= addr_in;
         issue_ff       <= issue_in;
         data_valid_ff  <= data_valid_in;
         data_last_ff   <= data_last_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_idx_ff       <= data_idx_in;
      op_ff             <= op_in;
      pos_ff            <= pos_in;
      node_ff           <= node_in;
      match_found_ff    <= match_found_in;
      match_idx_ff      <= match_idx_in;
      free_found_ff     <= free_found_in;
      free_idx_ff       <= free_idx_in;
      min_found_ff      <= min_found_in;
      min_key_ff        <= min_key_in;
      min_node_ff       <= min_node_in;
      succ_found_ff     <= succ_found_in;
      succ_key_ff       <= succ_key_in;
      succ_node_ff      <= succ_node_in;
      rsp_found_node_ff <= rsp_found_node_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found_node = rsp_found_node_ff;
   assign rsp_status     = rsp_status_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= FULL_COUNT)
      else $error("Ring entry count exceeds capacity.");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("Result raised outside the finish step.");

   a_write_when_idle_port: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_FINISH) && !issue_ff)
      else $error("Ring RAM written during a scan.");

   a_node_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_found_node_ff == '0)
      else $error("Node reported with a failing status.");

endmodule
`default_nettype wire
